@@ hw/rtl/nmfw_pkg.sv @@
// Shared types and constants for the NMF W multiplicative update block.
// Used by every module in hw/rtl but nmfw_div; depends on nothing.
package nmfw_pkg;

  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;
  localparam int unsigned DEF_MAX_RANK = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK = 2'd2;

  localparam logic [2:0] ACT_LOAD_W = 3'd0;
  localparam logic [2:0] ACT_LOAD_H = 3'd1;
  localparam logic [2:0] ACT_LOAD_V = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_READ_W = 3'd4;

  localparam logic RES_DONE = 1'b0;
  localparam logic RES_READ = 1'b1;

  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] result_value;
    logic        saturated;
  } out_item_t;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [31:0] value;
    logic        sat;
  } res_t;

endpackage

@@ hw/rtl/nmfw_div.sv @@
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
// Depends on nothing; the caller handles a zero divisor.
module nmfw_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);
  logic        run_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [47:0] dvd_q;
  logic [32:0] shifted;
  logic        fits;

  assign shifted = {rem_q, dvd_q[47]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        dvs_q <= divisor_i;
        dvd_q <= dividend_i;
      end else if (run_q) begin
        rem_q <= fits ? 32'(shifted - {1'b0, dvs_q}) : shifted[31:0];
        dvd_q <= {dvd_q[46:0], fits};
        if (cnt_q == 6'd47) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;
endmodule

@@ hw/rtl/nmfw_core.sv @@
// Sequencer, factor and data memories and Q16.16 arithmetic of the W update.
// Depends on nmfw_pkg and nmfw_div.
module nmfw_core #(
  parameter int unsigned MAX_ROWS = nmfw_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = nmfw_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_RANK = nmfw_pkg::DEF_MAX_RANK,
  parameter int unsigned NRW      = $clog2(MAX_ROWS + 1),
  parameter int unsigned NCW      = $clog2(MAX_COLS + 1),
  parameter int unsigned NKW      = $clog2(MAX_RANK + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nmfw_pkg::in_item_t in_data_i,
  input  logic [NRW-1:0]     nr_i,
  input  logic [NCW-1:0]     nc_i,
  input  logic [NKW-1:0]     nk_i,
  input  logic               out_free_i,
  output nmfw_pkg::res_t     res_o
);
  import nmfw_pkg::*;

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned KW  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int unsigned WD  = MAX_ROWS * MAX_RANK;
  localparam int unsigned HD  = MAX_COLS * MAX_RANK;
  localparam int unsigned VD  = MAX_ROWS * MAX_COLS;
  localparam int unsigned WAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int unsigned HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned VAW = (VD > 1) ? $clog2(VD) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_CS_RD, S_CS_ACC, S_WH_RD, S_WH_MUL, S_WH_ACC, S_V_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_DIV_WR, S_A_RD, S_A_MUL, S_A_ACC, S_U_MUL, S_U_SAT
  } state_e;

  state_e         state_q;
  logic           done_q;
  logic           sat_q;
  logic           rd_ok_q;
  logic           wphase_q;
  logic [RW-1:0]  i_q;
  logic [CW-1:0]  j_q;
  logic [KW-1:0]  k_q;
  logic [31:0]    acc_q;
  logic [63:0]    prod_q;
  logic [31:0]    div_a_q;
  logic [31:0]    div_b_q;
  logic [31:0]    quo_q;

  logic [31:0] w_mem [WD];
  logic [31:0] h_mem [HD];
  logic [31:0] v_mem [VD];
  logic [31:0] r_mem [MAX_COLS];
  logic [31:0] c_mem [MAX_RANK];
  logic [31:0] w_rd_q, h_rd_q, v_rd_q, r_rd_q, c_rd_q;

  logic           accept, idle, simple;
  logic           in_w_ok, in_h_ok, in_v_ok;
  logic [WAW-1:0] in_w_addr, seq_w_addr, w_ra, w_wa;
  logic [HAW-1:0] in_h_addr, seq_h_addr, h_ra;
  logic [VAW-1:0] in_v_addr, seq_v_addr;
  logic           w_we, h_we, v_we, r_we, c_we;
  logic [31:0]    w_wd;
  logic           last_i, last_j, last_k;
  logic [31:0]    mul_a, mul_b, mul_res, add_b, add_res;
  logic           mul_ovf, add_ovf;
  logic [32:0]    add_s;
  logic           div_start, div_done;
  logic [47:0]    div_q;

  assign idle   = state_q == S_IDLE;
  assign simple = (in_data_i.action != ACT_START) && (in_data_i.action != ACT_READ_W);
  // In the cycle that hands the update result over, the output register is
  // about to fill, so only loads are taken.
  assign in_ready_o = idle && (simple || (out_free_i && !done_q));
  assign accept = in_valid_i && in_ready_o;

  assign in_w_ok = (32'(in_data_i.row_index) < MAX_ROWS) && (32'(in_data_i.col_index) < MAX_RANK);
  assign in_h_ok = (32'(in_data_i.row_index) < MAX_COLS) && (32'(in_data_i.col_index) < MAX_RANK);
  assign in_v_ok = (32'(in_data_i.row_index) < MAX_ROWS) && (32'(in_data_i.col_index) < MAX_COLS);
  assign in_w_addr = WAW'(32'(in_data_i.row_index) * MAX_RANK + 32'(in_data_i.col_index));
  assign in_h_addr = HAW'(32'(in_data_i.row_index) * MAX_RANK + 32'(in_data_i.col_index));
  assign in_v_addr = VAW'(32'(in_data_i.row_index) * MAX_COLS + 32'(in_data_i.col_index));
  assign seq_w_addr = WAW'(32'(i_q) * MAX_RANK + 32'(k_q));
  assign seq_h_addr = HAW'(32'(j_q) * MAX_RANK + 32'(k_q));
  assign seq_v_addr = VAW'(32'(i_q) * MAX_COLS + 32'(j_q));

  assign last_i = (32'(i_q) + 32'd1) == 32'(nr_i);
  assign last_j = (32'(j_q) + 32'd1) == 32'(nc_i);
  assign last_k = (32'(k_q) + 32'd1) == 32'(nk_i);

  assign w_ra = idle ? in_w_addr : seq_w_addr;
  assign h_ra = seq_h_addr;
  assign w_we = (accept && in_data_i.action == ACT_LOAD_W && in_w_ok) ||
                (state_q == S_DIV_WR && wphase_q);
  assign w_wa = idle ? in_w_addr : seq_w_addr;
  assign w_wd = idle ? in_data_i.entry_value : quo_q;
  assign h_we = accept && in_data_i.action == ACT_LOAD_H && in_h_ok;
  assign v_we = accept && in_data_i.action == ACT_LOAD_V && in_v_ok;
  assign r_we = state_q == S_DIV_WR && !wphase_q;
  assign c_we = state_q == S_CS_ACC && last_j;

  // Memories: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    if (h_we) begin
      h_mem[in_h_addr] <= in_data_i.entry_value;
    end
    if (v_we) begin
      v_mem[in_v_addr] <= in_data_i.entry_value;
    end
    if (r_we) begin
      r_mem[j_q] <= quo_q;
    end
    if (c_we) begin
      c_mem[k_q] <= add_res;
    end
    w_rd_q <= w_mem[w_ra];
    h_rd_q <= h_mem[h_ra];
    v_rd_q <= v_mem[seq_v_addr];
    r_rd_q <= r_mem[j_q];
    c_rd_q <= c_mem[k_q];
  end

  // Shared multiplier operands and the saturating adder.
  always_comb begin
    case (state_q)
      S_A_MUL: begin
        mul_a = r_rd_q;
        mul_b = h_rd_q;
      end
      S_U_MUL: begin
        mul_a = w_rd_q;
        mul_b = acc_q;
      end
      default: begin
        mul_a = w_rd_q;
        mul_b = h_rd_q;
      end
    endcase
  end

  assign mul_ovf = |prod_q[63:48];
  assign mul_res = mul_ovf ? QMAX : prod_q[47:16];
  assign add_b   = (state_q == S_CS_ACC) ? h_rd_q : mul_res;
  assign add_s   = {1'b0, acc_q} + {1'b0, add_b};
  assign add_ovf = add_s[32];
  assign add_res = add_ovf ? QMAX : add_s[31:0];

  assign div_start = (state_q == S_DIV_GO) && (div_b_q != '0);

  nmfw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({div_a_q, 16'h0000}),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sat_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && in_data_i.action == ACT_READ_W) begin
            rd_ok_q <= in_w_ok;
            state_q <= S_RD_WAIT;
          end else if (accept && in_data_i.action == ACT_START) begin
            j_q     <= '0;
            k_q     <= '0;
            acc_q   <= '0;
            state_q <= S_CS_RD;
          end
        end
        S_RD_WAIT: begin
          state_q <= S_IDLE;
        end
        S_CS_RD: begin
          state_q <= S_CS_ACC;
        end
        S_CS_ACC: begin
          sat_q <= sat_q | add_ovf;
          if (last_j) begin
            acc_q <= '0;
            j_q   <= '0;
            if (last_k) begin
              i_q     <= '0;
              k_q     <= '0;
              state_q <= S_WH_RD;
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_CS_RD;
            end
          end else begin
            acc_q   <= add_res;
            j_q     <= j_q + CW'(1);
            state_q <= S_CS_RD;
          end
        end
        S_WH_RD: begin
          state_q <= S_WH_MUL;
        end
        S_WH_MUL, S_A_MUL: begin
          prod_q  <= mul_a * mul_b;
          state_q <= (state_q == S_WH_MUL) ? S_WH_ACC : S_A_ACC;
        end
        S_WH_ACC: begin
          sat_q <= sat_q | add_ovf | mul_ovf;
          acc_q <= add_res;
          if (last_k) begin
            state_q <= S_V_WAIT;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= S_WH_RD;
          end
        end
        S_V_WAIT: begin
          div_a_q  <= v_rd_q;
          div_b_q  <= acc_q;
          wphase_q <= 1'b0;
          state_q  <= S_DIV_GO;
        end
        S_DIV_GO: begin
          if (div_b_q == '0) begin
            sat_q   <= 1'b1;
            quo_q   <= QMAX;
            state_q <= S_DIV_WR;
          end else begin
            state_q <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            sat_q   <= sat_q | (|div_q[47:32]);
            quo_q   <= (|div_q[47:32]) ? QMAX : div_q[31:0];
            state_q <= S_DIV_WR;
          end
        end
        S_DIV_WR: begin
          acc_q <= '0;
          if (!wphase_q) begin
            k_q <= '0;
            if (last_j) begin
              j_q     <= '0;
              state_q <= S_A_RD;
            end else begin
              j_q     <= j_q + CW'(1);
              state_q <= S_WH_RD;
            end
          end else begin
            j_q <= '0;
            if (last_k) begin
              k_q <= '0;
              if (last_i) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                i_q     <= i_q + RW'(1);
                state_q <= S_WH_RD;
              end
            end else begin
              k_q     <= k_q + KW'(1);
              state_q <= S_A_RD;
            end
          end
        end
        S_A_RD: begin
          state_q <= S_A_MUL;
        end
        S_A_ACC: begin
          sat_q <= sat_q | add_ovf | mul_ovf;
          acc_q <= add_res;
          if (last_j) begin
            state_q <= S_U_MUL;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= S_A_RD;
          end
        end
        S_U_MUL: begin
          prod_q  <= mul_a * mul_b;
          div_b_q <= c_rd_q;
          state_q <= S_U_SAT;
        end
        S_U_SAT: begin
          sat_q    <= sat_q | mul_ovf;
          div_a_q  <= mul_res;
          wphase_q <= 1'b1;
          state_q  <= S_DIV_GO;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The W read result leaves in the cycle after the read is taken; the update
  // result leaves the cycle after the last W write.
  assign res_o.valid = (state_q == S_RD_WAIT) || done_q;
  assign res_o.kind  = (state_q == S_RD_WAIT) ? RES_READ : RES_DONE;
  assign res_o.value = ((state_q == S_RD_WAIT) && rd_ok_q) ? w_rd_q : '0;
  assign res_o.sat   = sat_q;
endmodule

@@ hw/rtl/nmf_w_multiplicative_update.sv @@
// A load is accepted every cycle while the sequencer is idle, also while a
// result waits. A W read's result passes the W read register and then the
// output register. An update runs over R rows, C columns and K rank, with a
// bit-serial division for each quotient, skipped when the divisor is zero.
// Reset clears the sequencer, output register and sticky flag and sets the
// row, column and rank registers to 64, 64 and 16, each capped at its maximum;
// the stores stay undefined.
module nmf_w_multiplicative_update #(
  parameter int unsigned MAX_ROWS = nmfw_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = nmfw_pkg::DEF_MAX_COLS,
  parameter int unsigned MAX_RANK = nmfw_pkg::DEF_MAX_RANK
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nmfw_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nmfw_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  nmfw_pkg::in_item_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output nmfw_pkg::out_item_t                  out_data_o
);
  import nmfw_pkg::*;

  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);
  localparam int unsigned NKW = $clog2(MAX_RANK + 1);

  // A value of zero counts as one; a value above the maximum is the maximum.
  function automatic int unsigned clamp(int unsigned v, int unsigned mx);
    int unsigned r;
    r = (v == 0) ? 1 : ((v > mx) ? mx : v);
    return r;
  endfunction

  logic [NRW-1:0] nr_q;
  logic [NCW-1:0] nc_q;
  logic [NKW-1:0] nk_q;
  logic           out_valid_q;
  out_item_t      out_data_q;
  res_t           res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q <= NRW'(clamp(64, MAX_ROWS));
      nc_q <= NCW'(clamp(64, MAX_COLS));
      nk_q <= NKW'(clamp(16, MAX_RANK));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: nr_q <= NRW'(clamp(32'(cfg_data_i), MAX_ROWS));
        CFG_COLS: nc_q <= NCW'(clamp(32'(cfg_data_i), MAX_COLS));
        CFG_RANK: nk_q <= NKW'(clamp(32'(cfg_data_i[4:0]), MAX_RANK));
        default: begin
        end
      endcase
    end
  end

  // The sequencer only produces a result when this register is empty, so a
  // new result never overwrites one still waiting for its transfer.
  nmfw_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_RANK (MAX_RANK),
    .NRW      (NRW),
    .NCW      (NCW),
    .NKW      (NKW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .nr_i       (nr_q),
    .nc_i       (nc_q),
    .nk_i       (nk_q),
    .out_free_i (!out_valid_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
      out_data_q  <= '{result_kind: res.kind, result_value: res.value, saturated: res.sat};
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
endmodule

@@ hw/rtl/nmfw_checker.sv @@
// Port-level checks for the NMF W update block, attached by bind.
// Depends on nmfw_pkg and the top level's ports.
module nmfw_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input nmfw_pkg::in_item_t      in_data_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input nmfw_pkg::out_item_t     out_data_o
);
  import nmfw_pkg::*;

  logic seen_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_sat_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && out_data_o.saturated) begin
      seen_sat_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed before its transfer");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_sat_q |-> out_data_o.saturated)
    else $error("saturation flag cleared");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == RES_DONE |-> out_data_o.result_value == '0)
    else $error("update result carries a value");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.action == ACT_START |=> !in_ready_o)
    else $error("input taken during an update");
endmodule

bind nmf_w_multiplicative_update nmfw_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
